// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fdc_pkg.sv =====
// package: types, opcodes and constants of the floppy disk controller
package fdc_pkg;

  localparam int DRIVE_COUNT_DEF       = 4;
  localparam int TRACK_COUNT_DEF       = 40;
  localparam int SECTORS_PER_TRACK_DEF = 16;
  localparam int SECTOR_BYTES_DEF      = 256;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_STATUS = 2'd2,
    ACT_LOAD   = 2'd3
  } action_e;

  typedef struct packed {
    logic       use_mem;
    logic [7:0] value;
  } resp_t;

  // opcodes
  localparam logic [4:0] OP_SENSE_DRIVE = 5'd4;
  localparam logic [4:0] OP_WRITE       = 5'd5;
  localparam logic [4:0] OP_READ        = 5'd6;
  localparam logic [4:0] OP_RECAL       = 5'd7;
  localparam logic [4:0] OP_SENSE_INT   = 5'd8;
  localparam logic [4:0] OP_READ_ID     = 5'd10;
  localparam logic [4:0] OP_SEEK        = 5'd15;

  localparam logic [3:0] CMD_MAX = 4'd9;

  localparam logic [3:0] CMD_LEN [32] = '{
    4'd1, 4'd1, 4'd9, 4'd3, 4'd2, 4'd9, 4'd9, 4'd2,
    4'd1, 4'd9, 4'd2, 4'd1, 4'd9, 4'd6, 4'd1, 4'd3,
    4'd1, 4'd9, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd9, 4'd1, 4'd1, 4'd1, 4'd1, 4'd9, 4'd1
  };

  // main status values and flags
  localparam logic [7:0] MSR_IDLE   = 8'h80;
  localparam logic [7:0] MSR_RESULT = 8'hD0;
  localparam logic [7:0] MSR_READ   = 8'hF0;
  localparam logic [7:0] MSR_WRITE  = 8'hB0;
  localparam logic [7:0] MSR_BUSY   = 8'h10;
  localparam logic [7:0] MSR_EXEC   = 8'h20;

  // status byte bits
  localparam logic [7:0] ST0_NO_DISK   = 8'hD8;
  localparam logic [7:0] ST0_ABNORMAL  = 8'h40;
  localparam logic [7:0] ST0_SEEK_END  = 8'h20;
  localparam logic [7:0] ST0_RECAL_ERR = 8'h30;
  localparam logic [7:0] ST0_FAULT     = 8'h38;
  localparam logic [7:0] ST0_MASK      = 8'h3F;
  localparam logic [7:0] ST0_NOT_READY = 8'h08;
  localparam logic [7:0] ST0_INVALID   = 8'h80;
  localparam logic [7:0] ST1_END_CYL   = 8'h80;
  localparam logic [7:0] ST3_WPROT     = 8'h40;
  localparam logic [7:0] ST3_READY     = 8'h20;
  localparam logic [7:0] ST3_TRACK0    = 8'h10;
  localparam logic [7:0] ST3_TWO_SIDE  = 8'h08;
  localparam logic [7:0] ID_SIZE_CODE  = 8'h41;
  localparam logic [7:0] RECAL_STEPS   = 8'd77;

endpackage

// ===== hw/rtl/fdc_disk_mem.sv =====
// disk image store: one write port, one registered read port
module fdc_disk_mem #(
  parameter int DEPTH = 655360,
  parameter int AW    = 20
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fdc_ctrl.sv =====
// command collection, command execution and transfer address logic
module fdc_ctrl #(
  parameter int DRIVE_COUNT       = fdc_pkg::DRIVE_COUNT_DEF,
  parameter int TRACK_COUNT       = fdc_pkg::TRACK_COUNT_DEF,
  parameter int SECTORS_PER_TRACK = fdc_pkg::SECTORS_PER_TRACK_DEF,
  parameter int SECTOR_BYTES      = fdc_pkg::SECTOR_BYTES_DEF,
  parameter int STORE_BYTES       = 655360,
  parameter int MEM_AW            = 20,
  parameter int XFER_AW           = 22,
  parameter int CNT_W             = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                fire_i,
  input  fdc_pkg::action_e    action_i,
  input  logic [7:0]          data_i,
  input  logic [19:0]         image_address_i,
  output logic                mem_we_o,
  output logic [MEM_AW-1:0]   mem_waddr_o,
  output logic [7:0]          mem_wdata_o,
  output logic                mem_re_o,
  output logic [MEM_AW-1:0]   mem_raddr_o,
  output fdc_pkg::resp_t      resp_o
);

  localparam int DRIVE_SPAN = TRACK_COUNT * SECTORS_PER_TRACK * SECTOR_BYTES;
  localparam int TRACK_SPAN = SECTORS_PER_TRACK * SECTOR_BYTES;

  logic [3:0]         present_q, present_d, wprot_q, wprot_d;
  logic [7:0]         cmd_q [9];
  logic [7:0]         cmd_d [9];
  logic [3:0]         cnt_q, cnt_d;
  logic               exec_q, exec_d, giving_q, giving_d;
  logic [7:0]         msr_q, msr_d;
  logic [7:0]         st_q [3];
  logic [7:0]         st_d [3];
  logic [7:0]         res_q [7];
  logic [7:0]         res_d [7];
  logic [2:0]         idx_q, idx_d, tot_q, tot_d;
  logic [1:0]         sel_q, sel_d;
  logic [7:0]         trk_q [4];
  logic [7:0]         trk_d [4];
  logic [XFER_AW-1:0] base_q, base_d;
  logic [CNT_W-1:0]   xcnt_q, xcnt_d, len_q, len_d;

  logic               run, give7, id_fix;
  logic [4:0]         op;
  logic [7:0]         c1, st, trk_rd, xtrk, sidx;
  logic [1:0]         drv, trk_idx;
  logic [8:0]         nsec, lim;
  logic [XFER_AW-1:0] xa, base_calc;

  function automatic logic has_disk(input logic [1:0] d, input logic [3:0] present);
    has_disk = ({1'b0, d} < 3'(DRIVE_COUNT)) && present[d];
  endfunction

  always_comb begin
    present_d = present_q;
    wprot_d   = wprot_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    exec_d    = exec_q;
    giving_d  = giving_q;
    msr_d     = msr_q;
    st_d      = st_q;
    res_d     = res_q;
    idx_d     = idx_q;
    tot_d     = tot_q;
    sel_d     = sel_q;
    trk_d     = trk_q;
    base_d    = base_q;
    xcnt_d    = xcnt_q;
    len_d     = len_q;
    run       = 1'b0;
    give7     = 1'b0;
    id_fix    = 1'b0;
    st        = '0;
    nsec      = '0;
    lim       = '0;
    xa        = base_q + XFER_AW'(xcnt_q);
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = data_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = MEM_AW'(xa);
    resp_o      = '{use_mem: 1'b0, value: 8'h00};

    if (cfg_we_i) begin
      if (cfg_index_i == 1'b0) begin
        present_d = cfg_data_i;
      end else begin
        wprot_d = cfg_data_i;
      end
    end

    // command byte collection
    if (fire_i && action_i == fdc_pkg::ACT_WRITE) begin
      if (exec_q) begin
        run = 1'b1;
      end else begin
        if (cnt_q == 4'd0) begin
          cmd_d[0] = {3'b000, data_i[4:0]};
          cnt_d    = 4'd1;
          msr_d    = msr_d | fdc_pkg::MSR_BUSY;
        end else if (cnt_q < fdc_pkg::CMD_LEN[cmd_q[0][4:0]] && cnt_q < fdc_pkg::CMD_MAX) begin
          cmd_d[cnt_q] = data_i;
          cnt_d        = cnt_q + 4'd1;
        end
        if (cnt_d >= fdc_pkg::CMD_LEN[cmd_d[0][4:0]]) begin
          cnt_d = 4'd0;
          msr_d = msr_d | fdc_pkg::MSR_EXEC;
          run   = 1'b1;
        end
      end
    end

    op      = cmd_d[0][4:0];
    c1      = cmd_d[1];
    drv     = c1[1:0];
    trk_idx = (op == fdc_pkg::OP_SENSE_INT) ? sel_q : drv;
    trk_rd  = trk_q[trk_idx];
    xtrk    = (op == fdc_pkg::OP_WRITE) ? cmd_d[2] : trk_rd;
    sidx    = (cmd_d[4] != 8'd0 && 32'(cmd_d[4]) <= SECTORS_PER_TRACK) ?
              cmd_d[4] - 8'd1 : 8'd0;
    base_calc = XFER_AW'(drv) * XFER_AW'(DRIVE_SPAN)
              + XFER_AW'(xtrk) * XFER_AW'(TRACK_SPAN)
              + XFER_AW'(sidx) * XFER_AW'(SECTOR_BYTES);

    if (run) begin
      case (op)
        fdc_pkg::OP_SENSE_DRIVE: begin
          sel_d = drv;
          st    = {5'b00000, c1[2:0]};
          if (wprot_q[drv]) st = st | fdc_pkg::ST3_WPROT;
          if (has_disk(drv, present_q)) st = st | fdc_pkg::ST3_READY;
          if (trk_rd == 8'd0) st = st | fdc_pkg::ST3_TRACK0;
          if (st[2]) st = st | fdc_pkg::ST3_TWO_SIDE;
          res_d[0] = st;
          tot_d    = 3'd1;
          idx_d    = 3'd0;
          exec_d   = 1'b0;
          giving_d = 1'b1;
          msr_d    = fdc_pkg::MSR_RESULT;
        end
        fdc_pkg::OP_WRITE: begin
          if (!exec_q) begin
            sel_d      = drv;
            trk_d[drv] = cmd_d[2];
            exec_d     = 1'b1;
            if (!has_disk(drv, present_q)) begin
              st_d[0] = {6'b000000, drv} | fdc_pkg::ST0_NO_DISK;
              give7   = 1'b1;
            end else begin
              nsec = (cmd_d[6] >= cmd_d[4]) ?
                     {1'b0, cmd_d[6]} - {1'b0, cmd_d[4]} + 9'd1 : 9'd1;
              lim  = 9'(SECTORS_PER_TRACK) - {1'b0, sidx};
              if (nsec > lim) nsec = lim;
              base_d = base_calc;
              len_d  = CNT_W'(nsec) * CNT_W'(SECTOR_BYTES);
              xcnt_d = '0;
              msr_d  = fdc_pkg::MSR_WRITE;
            end
          end else begin
            if (32'(xa) < 32'(STORE_BYTES)) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = MEM_AW'(xa);
            end
            xcnt_d = xcnt_q + CNT_W'(1);
            if (xcnt_d == len_q) begin
              st_d[0] = {5'b00000, c1[2:0]};
              give7   = 1'b1;
            end
          end
        end
        fdc_pkg::OP_READ: begin
          sel_d = drv;
          if (!has_disk(drv, present_q)) begin
            st_d[0] = {6'b000000, drv} | fdc_pkg::ST0_NO_DISK;
            give7   = 1'b1;
          end else begin
            exec_d = 1'b1;
            base_d = base_calc;
            len_d  = CNT_W'(SECTOR_BYTES);
            xcnt_d = '0;
            msr_d  = fdc_pkg::MSR_READ;
          end
        end
        fdc_pkg::OP_RECAL: begin
          st_d[1] = 8'h00;
          st_d[2] = 8'h00;
          sel_d   = drv;
          st      = {5'b00000, c1[2:0]};
          if (!has_disk(drv, present_q)) begin
            st = st | fdc_pkg::ST0_NO_DISK;
          end else if (trk_rd > fdc_pkg::RECAL_STEPS) begin
            trk_d[drv] = trk_rd - fdc_pkg::RECAL_STEPS;
            st         = st | fdc_pkg::ST0_RECAL_ERR;
          end else begin
            trk_d[drv] = 8'd0;
            st         = st | fdc_pkg::ST0_SEEK_END;
          end
          st_d[0] = st;
          msr_d   = fdc_pkg::MSR_IDLE | (8'd1 << drv);
          exec_d  = 1'b0;
        end
        fdc_pkg::OP_SENSE_INT: begin
          msr_d = fdc_pkg::MSR_RESULT;
          tot_d = 3'd2;
          idx_d = 3'd0;
          st    = st_q[0];
          if (!has_disk(sel_q, present_q)) st = st | fdc_pkg::ST0_NOT_READY;
          if ((st & fdc_pkg::ST0_FAULT) == 8'h00) st = st | fdc_pkg::ST0_INVALID;
          st       = st & fdc_pkg::ST0_MASK;
          res_d[0] = st;
          st_d[0]  = 8'h00;
          res_d[1] = trk_rd;
          exec_d   = 1'b0;
          giving_d = 1'b1;
        end
        fdc_pkg::OP_READ_ID: begin
          sel_d = drv;
          if (!has_disk(drv, present_q)) begin
            st_d[0] = {6'b000000, drv} | fdc_pkg::ST0_NO_DISK;
          end else begin
            st_d[0] = {5'b00000, c1[2:0]};
            id_fix  = 1'b1;
          end
          give7 = 1'b1;
        end
        fdc_pkg::OP_SEEK: begin
          msr_d = fdc_pkg::MSR_IDLE | (8'd1 << drv);
          sel_d = drv;
          if (!has_disk(drv, present_q)) begin
            st_d[0] = {6'b000000, drv} | fdc_pkg::ST0_NO_DISK;
            give7   = 1'b1;
          end else begin
            trk_d[drv] = cmd_d[2];
            st_d[0]    = fdc_pkg::ST0_SEEK_END | {5'b00000, c1[2:0]};
            exec_d     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (fire_i) begin
      case (action_i)
        fdc_pkg::ACT_READ: begin
          if (exec_q) begin
            if (cmd_q[0][4:0] == fdc_pkg::OP_READ) begin
              mem_re_o       = 1'b1;
              resp_o.use_mem = (32'(xa) < 32'(STORE_BYTES));
              xcnt_d         = xcnt_q + CNT_W'(1);
              if (xcnt_d == len_q) begin
                st_d[0] = {5'b00000, cmd_q[1][2:0]} | fdc_pkg::ST0_ABNORMAL;
                st_d[1] = fdc_pkg::ST1_END_CYL;
                give7   = 1'b1;
              end
            end
          end else if (giving_q) begin
            if (idx_q != 3'd7) resp_o.value = res_q[idx_q];
            idx_d = idx_q + 3'd1;
            if (idx_d == tot_q) begin
              msr_d    = fdc_pkg::MSR_IDLE;
              giving_d = 1'b0;
            end
          end
        end
        fdc_pkg::ACT_STATUS: begin
          resp_o.value = msr_q;
        end
        fdc_pkg::ACT_LOAD: begin
          if (32'(image_address_i) < 32'(STORE_BYTES)) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = MEM_AW'(image_address_i);
          end
        end
        default: begin
        end
      endcase
    end

    // seven-byte result phase
    if (give7) begin
      res_d[0] = st_d[0];
      res_d[1] = st_d[1];
      res_d[2] = st_d[2];
      res_d[3] = cmd_d[2];
      res_d[4] = cmd_d[3];
      res_d[5] = cmd_d[4];
      res_d[6] = cmd_d[5];
      msr_d    = fdc_pkg::MSR_RESULT;
      idx_d    = 3'd0;
      tot_d    = 3'd7;
      st_d[0]  = 8'h00;
      st_d[1]  = 8'h00;
      st_d[2]  = 8'h00;
      exec_d   = 1'b0;
      giving_d = 1'b1;
    end
    if (id_fix) res_d[5] = fdc_pkg::ID_SIZE_CODE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      wprot_q   <= '0;
      cmd_q     <= '{default: 8'h00};
      cnt_q     <= '0;
      exec_q    <= 1'b0;
      giving_q  <= 1'b0;
      msr_q     <= fdc_pkg::MSR_IDLE;
      st_q      <= '{default: 8'h00};
      idx_q     <= '0;
      tot_q     <= '0;
      sel_q     <= '0;
      trk_q     <= '{default: 8'h00};
      base_q    <= '0;
      xcnt_q    <= '0;
      len_q     <= '0;
    end else begin
      present_q <= present_d;
      wprot_q   <= wprot_d;
      cmd_q     <= cmd_d;
      cnt_q     <= cnt_d;
      exec_q    <= exec_d;
      giving_q  <= giving_d;
      msr_q     <= msr_d;
      st_q      <= st_d;
      idx_q     <= idx_d;
      tot_q     <= tot_d;
      sel_q     <= sel_d;
      trk_q     <= trk_d;
      base_q    <= base_d;
      xcnt_q    <= xcnt_d;
      len_q     <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== hw/rtl/floppy_disk_controller.sv =====
// top level of the floppy disk controller: handshake pipeline, control and disk store
//
// usage
// - input channel (in_valid_i / in_stall_o) carries one bus access per transfer:
//   data write, data read, status read or image byte load (action_i, data_i,
//   image_address_i)
// - output channel (out_valid_o / out_stall_i) returns exactly one read_data_o
//   per accepted access, in order; writes and loads return zero
// - configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) set disk present
//   (index 0) and write protect (index 1); issue them only while idle
// - an accepted access loads the stage register, and issues its store read, at
//   the accepting edge; its result moves on into the output register once that
//   register is free
// - throughput: one access per cycle while in_stall_o is low; the store has one
//   write and one registered read port and each access uses at most one of them
// - the store read port feeds a single stage register, so when the receiver
//   stalls with both that stage and the output register full, in_stall_o rises
// - reset clears the command, status and transfer state and the main status to
//   its idle value; the disk store keeps its contents and needs no clearing
module floppy_disk_controller #(
  parameter int DRIVE_COUNT       = fdc_pkg::DRIVE_COUNT_DEF,
  parameter int TRACK_COUNT       = fdc_pkg::TRACK_COUNT_DEF,
  parameter int SECTORS_PER_TRACK = fdc_pkg::SECTORS_PER_TRACK_DEF,
  parameter int SECTOR_BYTES      = fdc_pkg::SECTOR_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_i,
  input  logic [19:0] image_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o
);

  `include "assert_macros.svh"

  // store geometry and derived widths
  localparam int STORE_BYTES = DRIVE_COUNT * TRACK_COUNT * SECTORS_PER_TRACK * SECTOR_BYTES;
  localparam int MEM_AW      = $clog2(STORE_BYTES);
  // transfer addresses can point past the store (track taken from the command)
  localparam int XFER_AW     =
    $clog2(((DRIVE_COUNT - 1) * TRACK_COUNT + 256) * SECTORS_PER_TRACK * SECTOR_BYTES) + 1;
  localparam int CNT_W       = $clog2(SECTORS_PER_TRACK * SECTOR_BYTES + 1);

  logic              fire, out_free, s1_move;
  logic              s1_vld_q, s1_vld_d;
  fdc_pkg::resp_t    s1_q, resp;
  logic              out_vld_q, out_vld_d;
  logic [7:0]        out_data_q, out_data_d;
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // output register frees up when empty or when its transfer completes
  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_move    = s1_vld_q && out_free;
  // stall only when the stage register is full and cannot drain
  assign in_stall_o = s1_vld_q && !out_free;
  assign fire       = in_valid_i && !in_stall_o;

  fdc_ctrl #(
    .DRIVE_COUNT       (DRIVE_COUNT),
    .TRACK_COUNT       (TRACK_COUNT),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .SECTOR_BYTES      (SECTOR_BYTES),
    .STORE_BYTES       (STORE_BYTES),
    .MEM_AW            (MEM_AW),
    .XFER_AW           (XFER_AW),
    .CNT_W             (CNT_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fire_i          (fire),
    .action_i        (fdc_pkg::action_e'(action_i)),
    .data_i          (data_i),
    .image_address_i (image_address_i),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .resp_o          (resp)
  );

  // a read is issued only when the stage can take it, so the read data
  // register holds until the stage drains
  fdc_disk_mem #(
    .DEPTH (STORE_BYTES),
    .AW    (MEM_AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    s1_vld_d   = s1_vld_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (s1_move) begin
      s1_vld_d = 1'b0;
    end
    if (fire) begin
      s1_vld_d = 1'b1;
    end
    if (s1_move) begin
      out_vld_d  = 1'b1;
      out_data_d = s1_q.use_mem ? mem_rdata : s1_q.value;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_q <= resp;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_vld_q;
  assign read_data_o = out_data_q;

  `ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, s1_vld_q && out_vld_q, "stall while not full")
  `ASSERT_NXT(a_fire_stage, clk_i, rst_ni, fire, s1_vld_q, "accepted access lost")
  `ASSERT_NXT(a_move_out, clk_i, rst_ni, s1_move, out_vld_q, "stage transfer lost")

endmodule

// ===== bench/tb_floppy_disk_controller.sv =====
// testbench of the floppy disk controller: directed and random bus accesses checked against a predictor
module tb_floppy_disk_controller;

  localparam int unsigned SPT        = fdc_pkg::SECTORS_PER_TRACK_DEF;
  localparam int unsigned SEC_BYTES  = fdc_pkg::SECTOR_BYTES_DEF;
  localparam int unsigned DISK_BYTES =
    fdc_pkg::DRIVE_COUNT_DEF * fdc_pkg::TRACK_COUNT_DEF * SPT * SEC_BYTES;
  // cycles without any transfer on either channel before the run is called hung
  localparam int IDLE_LIMIT = 4000;
  // accesses the random test adds on top of the directed ones
  localparam int RANDOM_ITEMS = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  action_i;
  logic [7:0]  data_i;
  logic [19:0] image_address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;

  floppy_disk_controller u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .data_i         (data_i),
    .image_address_i(image_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // controller predictor: its own copy of registers, command state and disk
  // ---------------------------------------------------------------------------
  logic [3:0]  disk_mask, wprot_mask;
  logic [7:0]  cmd_b [9];
  int          cmd_cnt;
  bit          xfer_on, results_on;
  logic [7:0]  msr;
  logic [7:0]  st_b [4];
  logic [7:0]  res_b [7];
  logic [2:0]  res_idx, res_tot;
  logic [1:0]  sel_drv;
  logic [7:0]  trk [4];
  int unsigned xbase, xcnt, xlen;
  bit [7:0]    disk_mem [DISK_BYTES];
  bit          disk_set [DISK_BYTES];

  // expected read_data values, oldest first
  logic [7:0]  read_data_q [$];

  function automatic bit drive_ready(int d);
    return d < fdc_pkg::DRIVE_COUNT_DEF && disk_mask[d];
  endfunction

  // out-of-range sector numbers fall back to the first sector of the track
  function automatic int unsigned sec_base(int unsigned d, int unsigned t, int unsigned r);
    int unsigned s;
    s = (r >= 1 && r <= SPT) ? r - 1 : 0;
    return ((d * fdc_pkg::TRACK_COUNT_DEF + t) * SPT + s) * SEC_BYTES;
  endfunction

  function automatic void give_seven();
    res_b[0] = st_b[0];
    res_b[1] = st_b[1];
    res_b[2] = st_b[2];
    res_b[3] = cmd_b[2];
    res_b[4] = cmd_b[3];
    res_b[5] = cmd_b[4];
    res_b[6] = cmd_b[5];
    msr = fdc_pkg::MSR_RESULT;
    res_idx = 0;
    res_tot = 3'd7;
    st_b[0] = 0;
    st_b[1] = 0;
    st_b[2] = 0;
    xfer_on = 0;
    results_on = 1;
  endfunction

  function automatic void fail_no_disk();
    st_b[0] = {6'b0, sel_drv} | fdc_pkg::ST0_NO_DISK;
    give_seven();
  endfunction

  function automatic void model_reset();
    disk_mask = 0;
    wprot_mask = 0;
    foreach (cmd_b[i]) cmd_b[i] = 0;
    foreach (st_b[i]) st_b[i] = 0;
    foreach (res_b[i]) res_b[i] = 0;
    foreach (trk[i]) trk[i] = 0;
    cmd_cnt = 0;
    xfer_on = 0;
    results_on = 0;
    msr = fdc_pkg::MSR_IDLE;
    res_idx = 0;
    res_tot = 0;
    sel_drv = 0;
    xbase = 0;
    xcnt = 0;
    xlen = 0;
  endfunction

  function automatic void run_command(logic [7:0] v);
    logic [7:0]  c1, st;
    int unsigned d, s, n, r, eot, a;
    c1 = cmd_b[1];
    d = c1[1:0];
    case (cmd_b[0][4:0])
      fdc_pkg::OP_SENSE_DRIVE: begin
        sel_drv = c1[1:0];
        st = c1 & 8'h07;
        if (wprot_mask[d]) st |= fdc_pkg::ST3_WPROT;
        if (drive_ready(d)) st |= fdc_pkg::ST3_READY;
        if (trk[d] == 0) st |= fdc_pkg::ST3_TRACK0;
        if (st[2]) st |= fdc_pkg::ST3_TWO_SIDE;
        st_b[3] = st;
        res_b[0] = st;
        res_tot = 3'd1;
        res_idx = 0;
        xfer_on = 0;
        results_on = 1;
        msr = fdc_pkg::MSR_RESULT;
      end
      fdc_pkg::OP_WRITE: begin
        if (!xfer_on) begin
          r = cmd_b[4];
          eot = cmd_b[6];
          sel_drv = c1[1:0];
          trk[d] = cmd_b[2];
          xfer_on = 1;
          if (!drive_ready(d)) fail_no_disk();
          else begin
            s = (r >= 1 && r <= SPT) ? r - 1 : 0;
            n = (eot >= r) ? eot - r + 1 : 1;
            if (n > SPT - s) n = SPT - s;
            xbase = sec_base(d, trk[d], r);
            xlen = n * SEC_BYTES;
            xcnt = 0;
            msr = fdc_pkg::MSR_WRITE;
          end
        end else begin
          a = xbase + xcnt;
          if (a < DISK_BYTES) begin
            disk_mem[a] = v;
            disk_set[a] = 1;
          end
          xcnt++;
          if (xcnt == xlen) begin
            st_b[0] = c1 & 8'h07;
            give_seven();
          end
        end
      end
      fdc_pkg::OP_READ: begin
        sel_drv = c1[1:0];
        if (!drive_ready(d)) fail_no_disk();
        else begin
          xfer_on = 1;
          xbase = sec_base(d, trk[d], cmd_b[4]);
          xlen = SEC_BYTES;
          xcnt = 0;
          msr = fdc_pkg::MSR_READ;
        end
      end
      fdc_pkg::OP_RECAL: begin
        st_b[1] = 0;
        st_b[2] = 0;
        sel_drv = c1[1:0];
        st = c1 & 8'h07;
        if (!drive_ready(d)) st |= fdc_pkg::ST0_NO_DISK;
        else if (trk[d] > fdc_pkg::RECAL_STEPS) begin
          trk[d] = trk[d] - fdc_pkg::RECAL_STEPS;
          st |= fdc_pkg::ST0_RECAL_ERR;
        end else begin
          trk[d] = 0;
          st |= fdc_pkg::ST0_SEEK_END;
        end
        st_b[0] = st;
        msr = fdc_pkg::MSR_IDLE | (8'd1 << d);
        xfer_on = 0;
      end
      fdc_pkg::OP_SENSE_INT: begin
        msr = fdc_pkg::MSR_RESULT;
        res_tot = 3'd2;
        res_idx = 0;
        st = st_b[0];
        if (!drive_ready(sel_drv)) st |= fdc_pkg::ST0_NOT_READY;
        if ((st & fdc_pkg::ST0_FAULT) == 0) st |= fdc_pkg::ST0_INVALID;
        st &= fdc_pkg::ST0_MASK;
        res_b[0] = st;
        st_b[0] = 0;
        res_b[1] = trk[sel_drv];
        xfer_on = 0;
        results_on = 1;
      end
      fdc_pkg::OP_READ_ID: begin
        sel_drv = c1[1:0];
        if (!drive_ready(d)) fail_no_disk();
        else begin
          st_b[0] = c1 & 8'h07;
          give_seven();
          res_b[5] = fdc_pkg::ID_SIZE_CODE;
        end
      end
      fdc_pkg::OP_SEEK: begin
        msr = fdc_pkg::MSR_IDLE | (8'd1 << d);
        sel_drv = c1[1:0];
        if (!drive_ready(d)) fail_no_disk();
        else begin
          trk[d] = cmd_b[2];
          st_b[0] = fdc_pkg::ST0_SEEK_END | (c1 & 8'h07);
          xfer_on = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void data_written(logic [7:0] v);
    if (xfer_on) begin
      run_command(v);
      return;
    end
    if (cmd_cnt == 0) begin
      cmd_b[0] = v & 8'h1F;
      cmd_cnt = 1;
      msr |= fdc_pkg::MSR_BUSY;
    end else if (cmd_cnt < fdc_pkg::CMD_LEN[cmd_b[0][4:0]] && cmd_cnt < fdc_pkg::CMD_MAX) begin
      cmd_b[cmd_cnt] = v;
      cmd_cnt++;
    end
    if (cmd_cnt >= fdc_pkg::CMD_LEN[cmd_b[0][4:0]]) begin
      cmd_cnt = 0;
      msr |= fdc_pkg::MSR_EXEC;
      run_command(v);
    end
  endfunction

  function automatic logic [7:0] data_fetched();
    logic [7:0]  v;
    int unsigned a;
    v = 0;
    if (xfer_on) begin
      if (cmd_b[0][4:0] != fdc_pkg::OP_READ) return 0;
      a = xbase + xcnt;
      if (a < DISK_BYTES) v = disk_mem[a];
      xcnt++;
      if (xcnt == xlen) begin
        st_b[0] = (cmd_b[1] & 8'h07) | fdc_pkg::ST0_ABNORMAL;
        st_b[1] = fdc_pkg::ST1_END_CYL;
        give_seven();
      end
      return v;
    end
    if (results_on) begin
      if (res_idx < 7) v = res_b[res_idx];
      res_idx = res_idx + 3'd1;
      if (res_idx == res_tot) begin
        msr = fdc_pkg::MSR_IDLE;
        results_on = 0;
      end
    end
    return v;
  endfunction

  function automatic logic [7:0] bus_access(fdc_pkg::action_e act, logic [7:0] v,
                                            logic [19:0] a);
    case (act)
      fdc_pkg::ACT_WRITE:  data_written(v);
      fdc_pkg::ACT_READ:   return data_fetched();
      fdc_pkg::ACT_STATUS: return msr;
      default: if (a < DISK_BYTES) begin
        disk_mem[a] = v;
        disk_set[a] = 1;
      end
    endcase
    return 8'h00;
  endfunction

  // a read sector is fine when no disk is there, it lies outside the store, or
  // every byte of it has been written
  function automatic bit sector_safe(int unsigned d, int unsigned r);
    int unsigned b;
    if (!drive_ready(d)) return 1;
    b = sec_base(d, trk[d], r);
    if (b >= DISK_BYTES) return 1;
    for (int unsigned i = 0; i < SEC_BYTES; i++)
      if (!disk_set[b + i]) return 0;
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // idling, result checking and watchdog
  // ---------------------------------------------------------------------------
  bit quiet;       // stretch with no gaps and no stalls on either side
  bit read_ok;     // read data commands may only start from read_sector
  int sent_cnt;
  int mismatches;
  int idle_cycles;
  int stall_hold;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // receiver stalls: held for a random number of cycles, mostly short
  always @(posedge clk_i) begin
    if (stall_hold > 0) stall_hold <= stall_hold - 1;
    else begin
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_hold  <= pick_gap();
    end
  end

  // every result transfer is compared with the oldest expected value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (read_data_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: read_data %02h", read_data_o);
        mismatches++;
      end else if (read_data_o !== read_data_q[0]) begin
        if (mismatches < 10)
          $display("mismatch read_data: expected %02h actual %02h",
                   read_data_q[0], read_data_o);
        mismatches++;
        void'(read_data_q.pop_front());
      end else void'(read_data_q.pop_front());
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // one bus access; predicted at the edge where the transfer happens
  task automatic send(input fdc_pkg::action_e act, input logic [7:0] v,
                      input logic [19:0] a);
    int gap;
    // stray read data opcodes become recalibrate so no unwritten sector is read
    if (act == fdc_pkg::ACT_WRITE && !xfer_on && cmd_cnt == 0 &&
        v[4:0] == fdc_pkg::OP_READ && !read_ok)
      v[0] = 1'b1;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    data_i          <= v;
    image_address_i <= a;
    do @(posedge clk_i); while (in_stall_o);
    read_data_q.push_back(bus_access(act, v, a));
    sent_cnt++;
    if ($urandom_range(0, 199) == 0) quiet = !quiet;
  endtask

  task automatic wr(input logic [7:0] v);
    send(fdc_pkg::ACT_WRITE, v, 20'($urandom));
  endtask

  task automatic rd();
    send(fdc_pkg::ACT_READ, 8'($urandom), 20'($urandom));
  endtask

  task automatic status();
    send(fdc_pkg::ACT_STATUS, 8'($urandom), 20'($urandom));
  endtask

  // sends as many command bytes as the opcode takes
  task automatic send_cmd(input logic [7:0] c [9]);
    int n;
    n = fdc_pkg::CMD_LEN[c[0][4:0]];
    for (int i = 0; i < n; i++) wr(c[i]);
  endtask

  task automatic drain_results();
    while (results_on) rd();
  endtask

  // finish whatever command, transfer or result phase is still open
  task automatic settle();
    while (cmd_cnt != 0 || xfer_on || results_on) begin
      if (xfer_on && cmd_b[0][4:0] == fdc_pkg::OP_READ) rd();
      else if (xfer_on || cmd_cnt != 0) wr(8'($urandom));
      else rd();
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (read_data_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_drives(input logic [3:0] present, input logic [3:0] wprot);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= 1'b0;
    cfg_data_i  <= present;
    @(posedge clk_i);
    disk_mask = present;
    cfg_index_i <= 1'b1;
    cfg_data_i  <= wprot;
    @(posedge clk_i);
    wprot_mask = wprot;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_sector(input logic [1:0] d, input logic [7:0] t, input logic [7:0] r,
                              input logic [7:0] eot, input bit head);
    send_cmd('{{3'b000, fdc_pkg::OP_WRITE}, {5'b0, head, d}, t, {7'b0, head}, r, 8'd1, eot,
               8'h1B, 8'hFF});
    while (xfer_on) begin
      // a data read in the middle of a write answers zero
      if ($urandom_range(0, 29) == 0) rd();
      else if ($urandom_range(0, 29) == 0) status();
      else wr(8'($urandom));
    end
    drain_results();
  endtask

  task automatic read_sector(input logic [1:0] d, input logic [7:0] r, input bit head,
                             input int restart_pct);
    if (!sector_safe(d, r)) write_sector(d, trk[d], r, r, head);
    read_ok = 1;
    send_cmd('{{3'b000, fdc_pkg::OP_READ}, {5'b0, head, d}, trk[d], {7'b0, head}, r, 8'd1,
               r, 8'h1B, 8'hFF});
    read_ok = 0;
    while (xfer_on) begin
      // a data write restarts the read from its first byte
      if ($urandom_range(0, 999) < restart_pct) wr(8'($urandom));
      else rd();
    end
    drain_results();
  endtask

  task automatic sense_int();
    send_cmd('{{3'b000, fdc_pkg::OP_SENSE_INT}, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
               8'h0});
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_bus_basics();
    status();
    rd();                                   // nothing to give: zero
    send(fdc_pkg::ACT_LOAD, 8'hFF, 20'd0);
    send(fdc_pkg::ACT_LOAD, 8'h00, 20'(DISK_BYTES - 1));
    send(fdc_pkg::ACT_LOAD, 8'hA5, 20'(DISK_BYTES));  // outside the store: ignored
    send(fdc_pkg::ACT_LOAD, 8'h5A, 20'hFFFFF);
    status();
  endtask

  task automatic test_sense_drive();
    set_drives(4'hF, 4'h5);
    for (int d = 0; d < 4; d++) begin
      send_cmd('{8'hE0 | {3'b0, fdc_pkg::OP_SENSE_DRIVE}, 8'(d | ((d & 1) << 2)), 8'h0,
                 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0});
      status();
      drain_results();
    end
    set_drives(4'h0, 4'hA);
    send_cmd('{{3'b000, fdc_pkg::OP_SENSE_DRIVE}, 8'hFF, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
               8'h0});
    drain_results();
  endtask

  task automatic test_seek_recal();
    set_drives(4'h3, 4'h0);
    send_cmd('{{3'b000, fdc_pkg::OP_SEEK}, 8'h05, 8'd200, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
               8'h0});
    status();
    sense_int();
    // recalibrate from beyond 77 steps only gets part of the way
    for (int i = 0; i < 3; i++) begin
      send_cmd('{{3'b000, fdc_pkg::OP_RECAL}, 8'h01, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
                 8'h0});
      sense_int();
    end
    send_cmd('{{3'b000, fdc_pkg::OP_SEEK}, 8'h03, 8'd255, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
               8'h0});
    drain_results();                        // no disk: seven results
    send_cmd('{{3'b000, fdc_pkg::OP_RECAL}, 8'h02, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
               8'h0});
    sense_int();
    sense_int();                            // nothing pending, drive 2 absent: not ready
  endtask

  task automatic test_read_id();
    send_cmd('{{3'b000, fdc_pkg::OP_READ_ID}, 8'h04, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
               8'h0});
    drain_results();
    send_cmd('{{3'b000, fdc_pkg::OP_READ_ID}, 8'h03, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
               8'h0});
    drain_results();
  endtask

  task automatic test_transfers();
    set_drives(4'hF, 4'h0);
    write_sector(2'd0, 8'd0, 8'd16, 8'd40, 1'b0);   // cut at the end of the track
    read_sector(2'd0, 8'd16, 1'b0, 2);              // with occasional restarts
    write_sector(2'd3, 8'd200, 8'd0, 8'd0, 1'b0);   // sector 0, outside the store
    set_drives(4'h0, 4'hF);
    write_sector(2'd0, 8'd3, 8'd1, 8'd1, 1'b0);     // no disk
    read_sector(2'd1, 8'd1, 1'b0, 0);
    // unimplemented opcodes leave busy and execution set
    send_cmd('{8'h03, 8'h11, 8'h22, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0});
    status();
    send_cmd('{8'hFF, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0});
    status();
    set_drives(4'hF, 4'h0);
  endtask

  task automatic test_random();
    int          stop_at, r, n;
    logic [7:0]  c [9];
    stop_at = sent_cnt + RANDOM_ITEMS;
    while (sent_cnt < stop_at) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 16) begin
        write_sector(2'($urandom), ($urandom_range(0, 9) == 0) ? 8'($urandom)
                     : 8'($urandom_range(0, 39)), 8'($urandom_range(1, 16)),
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0, 1'($urandom));
      end else if (r < 30) begin
        read_sector(2'($urandom), ($urandom_range(0, 9) == 0) ? 8'($urandom)
                    : 8'($urandom_range(1, 16)), 1'($urandom), 5);
      end else if (r < 45) begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
          send(fdc_pkg::action_e'($urandom_range(0, 3)), 8'($urandom), 20'($urandom));
      end else if (r < 60) begin
        foreach (c[i]) c[i] = 8'($urandom);
        c[0] = {3'($urandom), ($urandom_range(0, 1) != 0) ? fdc_pkg::OP_SEEK
                                                           : fdc_pkg::OP_RECAL};
        if ($urandom_range(0, 1) != 0) c[2] = 8'($urandom_range(0, 39));
        send_cmd(c);
        drain_results();
        if ($urandom_range(0, 3) != 0) sense_int();
      end else if (r < 70) begin
        foreach (c[i]) c[i] = 8'($urandom);
        c[0] = {3'($urandom), ($urandom_range(0, 1) != 0) ? fdc_pkg::OP_SENSE_DRIVE
                                                           : fdc_pkg::OP_READ_ID};
        send_cmd(c);
        status();
        drain_results();
      end else if (r < 78) begin
        foreach (c[i]) c[i] = 8'($urandom);
        if (c[0][4:0] == fdc_pkg::OP_READ) c[0][0] = 1'b1;
        send_cmd(c);
        status();
      end else if (r < 84) begin
        set_drives(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF, 4'($urandom));
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          send(fdc_pkg::ACT_LOAD, 8'($urandom), ($urandom_range(0, 3) == 0) ? 20'($urandom)
               : 20'($urandom_range(0, DISK_BYTES - 1)));
      end
    end
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = 1'b0;
    cfg_data_i      = 4'h0;
    in_valid_i      = 1'b0;
    action_i        = fdc_pkg::ACT_STATUS;
    data_i          = 8'h00;
    image_address_i = 20'h0;
    out_stall_i     = 1'b0;
    quiet           = 1'b0;
    read_ok         = 1'b0;
    sent_cnt        = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    stall_hold      = 0;
    model_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bus_basics();
    test_sense_drive();
    test_seek_recal();
    test_read_id();
    test_transfers();
    test_random();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fdc_pkg.sv
hw/rtl/fdc_disk_mem.sv
hw/rtl/fdc_ctrl.sv
hw/rtl/floppy_disk_controller.sv
bench/tb_floppy_disk_controller.sv
